### hdl/pdmd_pkg.sv
// ----------------------------------------------------------------------------
// pdmd_pkg
// Shared types, widths and register codes of the PD position motor drive.
// ----------------------------------------------------------------------------
package pdmd_pkg;

  // payload widths
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned ENC_W   = 24;
  localparam int unsigned DRIVE_W = 9;
  localparam int unsigned SPEED_W = 8;
  localparam int unsigned GAIN_W  = 16;

  // internal datapath widths
  localparam int unsigned TGT_W = 32;  // distance times counts per distance, Q.8
  localparam int unsigned ERR_W = 34;  // setpoint plus count, possibly negated
  localparam int unsigned PV_W  = 52;  // PD sum, Q.16

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P   = 3'd0,
    CFG_GAIN_D   = 3'd1,
    CFG_STOP_BND = 3'd2,
    CFG_MIN_SPD  = 3'd3,
    CFG_MAX_SPD  = 3'd4,
    CFG_CNT_DIST = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_TICK  = 1'b1
  } req_type_e;

  // register reset values
  localparam logic [GAIN_W-1:0]  GAIN_P_RST   = 16'd51;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST   = 16'd256;
  localparam logic [GAIN_W-1:0]  STOP_BND_RST = 16'd77;
  localparam logic [SPEED_W-1:0] MIN_SPD_RST  = 8'd50;
  localparam logic [SPEED_W-1:0] MAX_SPD_RST  = 8'd200;
  localparam logic [GAIN_W-1:0]  CNT_DIST_RST = 16'd256;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_d;
    logic [GAIN_W-1:0]  stop_band;
    logic [SPEED_W-1:0] min_speed;
    logic [SPEED_W-1:0] max_speed;
    logic [GAIN_W-1:0]  counts_per_distance;
  } cfg_t;

  typedef struct packed {
    req_type_e          req_type;
    logic [DIST_W-1:0]  move_distance;
    logic [ENC_W-1:0]   encoder_count;
  } req_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] motor_drive;
    logic               brake_now;
    logic               move_done;
  } rsp_t;

  typedef struct packed {
    logic [TGT_W-1:0] target;
    logic [ERR_W-1:0] prev_err;
    logic             active;
  } state_t;

endpackage

### hdl/pdmd_if.sv
// ----------------------------------------------------------------------------
// pdmd interfaces
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface pdmd_req_if import pdmd_pkg::*; ();
  logic              valid;
  logic              ready;
  req_type_e         req_type;
  logic [DIST_W-1:0] move_distance;
  logic [ENC_W-1:0]  encoder_count;

  modport source (output valid, req_type, move_distance, encoder_count, input ready);
  modport sink   (input valid, req_type, move_distance, encoder_count, output ready);
endinterface

interface pdmd_rsp_if import pdmd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DRIVE_W-1:0] motor_drive;
  logic               brake_now;
  logic               move_done;

  modport source (output valid, motor_drive, brake_now, move_done, input ready);
  modport sink   (input valid, motor_drive, brake_now, move_done, output ready);
endinterface

interface pdmd_cfg_if import pdmd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/pdmd_cfg_regs.sv
// ----------------------------------------------------------------------------
// pdmd_cfg_regs
// Gain, deadband, speed limit and scale registers behind the write channel.
// ----------------------------------------------------------------------------
module pdmd_cfg_regs import pdmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pdmd_cfg_if.sink    cfg_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_GAIN_P:   cfg_d.gain_p              = cfg_i.data;
        CFG_GAIN_D:   cfg_d.gain_d              = cfg_i.data;
        CFG_STOP_BND: cfg_d.stop_band           = cfg_i.data;
        CFG_MIN_SPD:  cfg_d.min_speed           = cfg_i.data[SPEED_W-1:0];
        CFG_MAX_SPD:  cfg_d.max_speed           = cfg_i.data[SPEED_W-1:0];
        CFG_CNT_DIST: cfg_d.counts_per_distance = cfg_i.data;
        default:      cfg_d = cfg_q;  // unused index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p              <= GAIN_P_RST;
      cfg_q.gain_d              <= GAIN_D_RST;
      cfg_q.stop_band           <= STOP_BND_RST;
      cfg_q.min_speed           <= MIN_SPD_RST;
      cfg_q.max_speed           <= MAX_SPD_RST;
      cfg_q.counts_per_distance <= CNT_DIST_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/pdmd_datapath.sv
// ----------------------------------------------------------------------------
// pdmd_datapath
// Error, PD sum, deadband test and speed clamp for one request.
// ----------------------------------------------------------------------------
module pdmd_datapath import pdmd_pkg::*; (
  input  req_t   req_i,
  input  state_t state_i,
  input  cfg_t   cfg_i,
  output state_t state_o,
  output rsp_t   rsp_o
);

  localparam int unsigned HI_W = PV_W - 16;

  logic signed [TGT_W:0]   start_prod;
  logic signed [ERR_W-1:0] err_sum;
  logic signed [ERR_W-1:0] err;
  logic signed [ERR_W:0]   err_diff;
  logic signed [PV_W-1:0]  pv_p;
  logic signed [PV_W-1:0]  pv_d_raw;
  logic signed [PV_W-1:0]  pv_d;
  logic signed [PV_W-1:0]  pv;
  logic [PV_W-1:0]         mag;
  logic                    in_band;
  logic [HI_W-1:0]         mag_hi;
  logic [HI_W-1:0]         min_ext;
  logic [HI_W-1:0]         max_ext;
  logic [HI_W-1:0]         raised;
  logic [SPEED_W-1:0]      speed;
  logic [DRIVE_W-1:0]      drive;
  logic                    dir_neg;

  // setpoint in Q.8 counts
  assign start_prod = $signed(req_i.move_distance)
                    * $signed({1'b0, cfg_i.counts_per_distance});

  assign dir_neg = state_i.target[TGT_W-1];

  // error in Q.8, folded so that a positive value means still to go
  assign err_sum = ERR_W'($signed(state_i.target))
                 + ERR_W'($signed({req_i.encoder_count, 8'h00}));
  assign err     = dir_neg ? -err_sum : err_sum;

  assign err_diff = (ERR_W+1)'(err) - (ERR_W+1)'($signed(state_i.prev_err));

  // PD sum in Q.16, derivative skipped on the first tick of a move
  assign pv_p     = $signed({1'b0, cfg_i.gain_p}) * err;
  assign pv_d_raw = $signed({1'b0, cfg_i.gain_d}) * err_diff;
  assign pv_d     = (state_i.prev_err != '0) ? pv_d_raw : '0;
  assign pv       = pv_p + pv_d;

  assign mag     = pv[PV_W-1] ? -pv : pv;
  assign in_band = mag <= PV_W'({cfg_i.stop_band, 8'h00});

  // raise to min first, then cap at max
  assign mag_hi  = mag[PV_W-1:16];
  assign min_ext = HI_W'(cfg_i.min_speed);
  assign max_ext = HI_W'(cfg_i.max_speed);
  assign raised  = (mag_hi < min_ext) ? min_ext : mag_hi;
  assign speed   = (raised > max_ext) ? cfg_i.max_speed : raised[SPEED_W-1:0];
  assign drive   = dir_neg ? -{1'b0, speed} : {1'b0, speed};

  always_comb begin
    state_o = state_i;
    rsp_o   = '0;
    unique case (req_i.req_type)
      REQ_START: begin
        state_o.target   = start_prod[TGT_W-1:0];
        state_o.prev_err = '0;
        state_o.active   = start_prod != '0;
        rsp_o.move_done  = start_prod == '0;
      end
      REQ_TICK: begin
        if (state_i.active) begin
          state_o.prev_err = err;
          if (in_band) begin
            state_o.active  = 1'b0;
            rsp_o.brake_now = 1'b1;
            rsp_o.move_done = 1'b1;
          end else begin
            rsp_o.motor_drive = drive;
          end
        end else begin
          rsp_o.move_done = 1'b1;
        end
      end
      default: begin
        rsp_o.move_done = 1'b1;
      end
    endcase
  end

endmodule

### hdl/pd_position_motor_drive_unit.sv
// ----------------------------------------------------------------------------
// pd_position_motor_drive_unit
// Point-to-point PD position controller for a two-wheel drive.
// ----------------------------------------------------------------------------
// A start request loads a signed distance, scales it by counts_per_distance
// into a Q.8 encoder setpoint and arms the loop; each tick request brings the
// encoder count and returns one signed drive value for both wheels, or a brake
// flag once the PD value falls inside the deadband. Every request gives
// exactly one result: it waits in the input register, then passes the error,
// PD and clamp logic into the result register once that is free or being
// emptied. The block takes one request per cycle while results are taken;
// the loop state (setpoint, last error, active flag) is updated in that same
// single pass, so a tick may follow a start in the very next cycle. Registers
// are written through the configuration channel, which is always ready, and
// should only change while no request is in flight.
module pd_position_motor_drive_unit import pdmd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  pdmd_req_if.sink      req_i,
  pdmd_rsp_if.source    rsp_o,
  pdmd_cfg_if.sink      cfg_i
);

  cfg_t   cfg;

  // input register
  logic   in_vld_q, in_vld_d;
  req_t   in_req_q;
  req_t   req_in;

  // loop state
  state_t state_q, state_d;

  // result register
  logic   out_vld_q, out_vld_d;
  rsp_t   out_rsp_q;
  rsp_t   rsp_next;

  logic   req_take;
  logic   advance;

  pdmd_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // the staged request moves on when the result slot is free or being emptied
  assign advance     = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || advance;
  assign req_take    = req_i.valid && req_i.ready;

  assign req_in.req_type      = req_i.req_type;
  assign req_in.move_distance = req_i.move_distance;
  assign req_in.encoder_count = req_i.encoder_count;

  pdmd_datapath u_datapath (
    .req_i   (in_req_q),
    .state_i (state_q),
    .cfg_i   (cfg),
    .state_o (state_d),
    .rsp_o   (rsp_next)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (req_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // control and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (req_take) begin
      in_req_q <= req_in;
    end
    if (advance) begin
      out_rsp_q <= rsp_next;
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.motor_drive = out_rsp_q.motor_drive;
  assign rsp_o.brake_now   = out_rsp_q.brake_now;
  assign rsp_o.move_done   = out_rsp_q.move_done;

endmodule

### tb/pd_drive_checker.sv
// ----------------------------------------------------------------------------
// pd_drive_checker
// Watches the request, result and register channels of the PD motor drive,
// predicts every result and compares it against what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pd_drive_checker import pdmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pdmd_req_if         req_i,
  pdmd_rsp_if         rsp_i,
  pdmd_cfg_if         cfg_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);

  localparam int unsigned SHOWN_MAX = 10;

  cfg_t        regs;
  longint      setpoint;
  longint      last_err;
  bit          armed;
  rsp_t        drive_q[$];
  int unsigned mismatches;

  // one pass of the PD loop for an accepted request
  task automatic step_controller(input req_type_e kind, input logic [DIST_W-1:0] move_dist,
                                 input logic [ENC_W-1:0] enc, output rsp_t res);
    longint err;
    longint pv;
    longint mag;
    longint drive;
    res = '0;
    if (kind == REQ_START) begin
      setpoint = longint'($signed(move_dist)) * longint'(regs.counts_per_distance);
      last_err = 0;
      armed    = (setpoint != 0);
    end else if (armed) begin
      err = setpoint + longint'($signed(enc)) * 256;
      if (setpoint < 0) err = -err;
      pv = longint'(regs.gain_p) * err;
      if (last_err != 0) pv += longint'(regs.gain_d) * (err - last_err);
      last_err = err;
      mag = (pv < 0) ? -pv : pv;
      if (mag <= longint'(regs.stop_band) * 256) begin
        res.brake_now = 1'b1;
        armed = 1'b0;
      end else begin
        mag = mag >>> 16;
        if (mag < longint'(regs.min_speed)) mag = longint'(regs.min_speed);
        if (mag > longint'(regs.max_speed)) mag = longint'(regs.max_speed);
        drive = (setpoint < 0) ? -mag : mag;
        res.motor_drive = drive[DRIVE_W-1:0];
      end
    end
    res.move_done = !armed;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    rsp_t got;
    if (!rst_ni) begin
      regs = '{GAIN_P_RST, GAIN_D_RST, STOP_BND_RST, MIN_SPD_RST, MAX_SPD_RST, CNT_DIST_RST};
      setpoint   = 0;
      last_err   = 0;
      armed      = 1'b0;
      mismatches = 0;
      drive_q.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_GAIN_P:   regs.gain_p              = cfg_i.data;
          CFG_GAIN_D:   regs.gain_d              = cfg_i.data;
          CFG_STOP_BND: regs.stop_band           = cfg_i.data;
          CFG_MIN_SPD:  regs.min_speed           = cfg_i.data[SPEED_W-1:0];
          CFG_MAX_SPD:  regs.max_speed           = cfg_i.data[SPEED_W-1:0];
          CFG_CNT_DIST: regs.counts_per_distance = cfg_i.data;
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) begin
        step_controller(req_i.req_type, req_i.move_distance, req_i.encoder_count, want);
        drive_q.push_back(want);
      end
      if (rsp_i.valid && rsp_i.ready) begin
        got = '{rsp_i.motor_drive, rsp_i.brake_now, rsp_i.move_done};
        if (drive_q.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_MAX)
            $display("%0t: drive result with none pending: drive %0d brake %0b done %0b",
                     $realtime, $signed(got.motor_drive), got.brake_now, got.move_done);
        end else begin
          want = drive_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= SHOWN_MAX)
              $display("%0t: exp drive %0d brake %0b done %0b, got drive %0d brake %0b done %0b",
                       $realtime, $signed(want.motor_drive), want.brake_now, want.move_done,
                       $signed(got.motor_drive), got.brake_now, got.move_done);
          end
        end
      end
    end
    mismatch_cnt_o <= mismatches;
    pending_o      <= drive_q.size();
  end

endmodule

### tb/tb_pd_position_motor_drive_unit.sv
// ----------------------------------------------------------------------------
// tb_pd_position_motor_drive_unit
// Drives start and tick requests plus register writes into the PD motor drive
// with random idling on both channels; a checker beside the block predicts
// and compares every result, this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_pd_position_motor_drive_unit;
  import pdmd_pkg::*;

  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 160;
  localparam int unsigned DRAIN_CYCLES = 4;   // extra wait after the result backlog is empty
  localparam int          SPARE_IDX_FIRST = CFG_CNT_DIST + 1;
  localparam int          SPARE_IDX_LAST  = (1 << CFG_IDX_W) - 1;
  localparam longint      ENC_MAX = (longint'(1) << (ENC_W - 1)) - 1;
  localparam longint      ENC_MIN = -(longint'(1) << (ENC_W - 1));

  // flavors of register settings used per phase
  typedef enum int {
    REGS_RESET,
    REGS_ZERO,
    REGS_ONES,
    REGS_TUNED,
    REGS_WILD
  } regs_style_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatch_cnt;
  int unsigned result_backlog;
  bit          steady;      // no idling on either side while set
  cfg_t        regs_now;    // what was last written, used to shape moves only

  pdmd_req_if req_if ();
  pdmd_rsp_if rsp_if ();
  pdmd_cfg_if cfg_if ();

  pd_position_motor_drive_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  pd_drive_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_if),
    .rsp_i          (rsp_if),
    .cfg_i          (cfg_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (result_backlog)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // safety net against a hung handshake
  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // idle length for either side: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // clamp a wanted encoder count into the 24 bit field
  function automatic logic [ENC_W-1:0] enc_fit(longint cnt);
    if (cnt > ENC_MAX) cnt = ENC_MAX;
    if (cnt < ENC_MIN) cnt = ENC_MIN;
    return cnt[ENC_W-1:0];
  endfunction

  function automatic cfg_t regs_for(regs_style_e style);
    cfg_t c;
    case (style)
      REGS_RESET: c = '{GAIN_P_RST, GAIN_D_RST, STOP_BND_RST, MIN_SPD_RST, MAX_SPD_RST,
                        CNT_DIST_RST};
      REGS_ZERO:  c = '0;
      REGS_ONES:  c = '1;
      REGS_TUNED: begin
        // values where moves actually settle into the deadband
        c.gain_p              = 16'($urandom_range(1, 2000));
        c.gain_d              = 16'($urandom_range(0, 4000));
        c.stop_band           = 16'($urandom_range(0, 20000));
        c.min_speed           = 8'($urandom_range(0, 100));
        c.max_speed           = 8'($urandom_range(60, 255));
        c.counts_per_distance = 16'($urandom_range(1, 2048));
      end
      default: begin
        c.gain_p              = 16'($urandom);
        c.gain_d              = 16'($urandom);
        c.stop_band           = 16'($urandom);
        c.min_speed           = 8'($urandom);
        c.max_speed           = 8'($urandom);
        c.counts_per_distance = 16'($urandom);
      end
    endcase
    return c;
  endfunction

  // one request on the request channel; valid stays up if no gap follows
  task automatic issue(input req_type_e kind, input logic [DIST_W-1:0] move_dist,
                       input logic [ENC_W-1:0] enc);
    int unsigned gap;
    req_if.valid         <= 1'b1;
    req_if.req_type      <= kind;
    req_if.move_distance <= move_dist;
    req_if.encoder_count <= enc;
    do @(posedge clk_i); while (!req_if.ready);
    gap = idle_len();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // full register set, back to back, plus one write to an unused index
  task automatic load_regs(input cfg_t c);
    put_reg(CFG_GAIN_P, c.gain_p);
    put_reg(CFG_GAIN_D, c.gain_d);
    put_reg(CFG_STOP_BND, c.stop_band);
    put_reg(CFG_MIN_SPD, {8'($urandom), c.min_speed});
    put_reg(CFG_MAX_SPD, {8'($urandom), c.max_speed});
    put_reg(CFG_CNT_DIST, c.counts_per_distance);
    put_reg(CFG_IDX_W'($urandom_range(SPARE_IDX_FIRST, SPARE_IDX_LAST)), 16'($urandom));
    cfg_if.valid <= 1'b0;
    regs_now = c;
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (result_backlog != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // well-formed move: start, encoder creeping toward the setpoint, then
  // a few ticks parked on it so the deadband can end the move
  task automatic run_move(inout int unsigned sent);
    longint      move_dist;
    longint      goal;
    longint      cnt;
    int unsigned steps;
    int unsigned settle;
    int unsigned k;
    if ($urandom_range(0, 9) == 0) move_dist = longint'($signed(16'($urandom)));
    else begin
      move_dist = $urandom_range(1, 300);
      if ($urandom_range(0, 1) == 1) move_dist = -move_dist;
    end
    // error is setpoint plus count, so the count heads for minus the setpoint
    goal   = -(move_dist * longint'(regs_now.counts_per_distance)) / 256;
    steps  = $urandom_range(1, 14);
    settle = $urandom_range(1, 3);
    issue(REQ_START, 16'(move_dist), 24'($urandom));
    for (k = 1; k <= steps; k++) begin
      cnt = goal * longint'(k) / longint'(steps) + longint'($urandom_range(0, 6)) - 3;
      issue(REQ_TICK, 16'($urandom), enc_fit(cnt));
    end
    for (k = 0; k < settle; k++)
      issue(REQ_TICK, 16'($urandom), enc_fit(goal + (($urandom_range(0, 3) == 0) ? 1 : 0)));
    sent += 1 + steps + settle;
  endtask

  // broken sequences: lone ticks, bare starts, extreme counts
  task automatic noise_item(inout int unsigned sent);
    logic [ENC_W-1:0] enc;
    case ($urandom_range(0, 3))
      0:       enc = enc_fit(ENC_MAX);
      1:       enc = enc_fit(ENC_MIN);
      default: enc = 24'($urandom);
    endcase
    if ($urandom_range(0, 1) == 1) issue(REQ_TICK, 16'($urandom), enc);
    else issue(REQ_START, ($urandom_range(0, 4) == 0) ? '0 : 16'($urandom), enc);
    sent++;
  endtask

  // result side: ready runs of random length broken by stalls
  initial begin
    int unsigned run;
    int unsigned stall;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      run = $urandom_range(1, 12);
      rsp_if.ready <= 1'b1;
      repeat (run) @(posedge clk_i);
      stall = idle_len();
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    cfg_t        c;
    regs_style_e style;
    int unsigned sent;
    int unsigned phase;

    rst_ni               <= 1'b0;
    req_if.valid         <= 1'b0;
    req_if.req_type      <= REQ_TICK;
    req_if.move_distance <= '0;
    req_if.encoder_count <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= '0;
    cfg_if.data          <= '0;
    steady = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    regs_now = regs_for(REGS_RESET);

    // --- directed, reset register values
    issue(REQ_TICK, 16'($urandom), enc_fit(ENC_MAX));   // tick while idle
    issue(REQ_START, '0, 24'($urandom));                // zero setpoint arms nothing
    issue(REQ_START, 16'h7FFF, '0);                     // farthest forward move
    issue(REQ_TICK, 16'($urandom), '0);
    issue(REQ_TICK, 16'($urandom), enc_fit(ENC_MIN));   // far overshoot, sign by direction
    issue(REQ_TICK, 16'($urandom), enc_fit(ENC_MAX));
    issue(REQ_START, 16'h8000, '0);                     // farthest reverse move
    issue(REQ_TICK, 16'($urandom), '0);
    issue(REQ_TICK, 16'($urandom), 24'd32768);          // on target, derivative still kicks
    issue(REQ_TICK, 16'($urandom), 24'd32768);          // on target twice: brake
    issue(REQ_TICK, 16'($urandom), 24'd32768);          // disarmed again
    issue(REQ_START, 16'd100, '0);
    issue(REQ_START, -16'sd5, '0);                      // new start replaces live move
    issue(REQ_TICK, 16'($urandom), 24'd5);              // first tick already inside band
    drain();

    // --- zero deadband and zero floor: tiny drive rounds to zero, move goes on
    c = regs_for(REGS_RESET);
    c.stop_band = '0;
    c.min_speed = '0;
    c.max_speed = '1;
    load_regs(c);
    issue(REQ_START, 16'd1, '0);
    issue(REQ_TICK, 16'($urandom), '0);
    issue(REQ_TICK, 16'($urandom), '1);
    issue(REQ_TICK, 16'($urandom), '1);
    drain();

    // --- floor above ceiling: ceiling wins; largest scale factor
    c = regs_for(REGS_RESET);
    c.min_speed           = '1;
    c.max_speed           = 8'd10;
    c.counts_per_distance = '1;
    load_regs(c);
    issue(REQ_START, 16'h8000, '0);
    issue(REQ_TICK, 16'($urandom), '0);
    issue(REQ_TICK, 16'($urandom), enc_fit(ENC_MAX));
    issue(REQ_START, 16'h7FFF, '0);
    issue(REQ_TICK, 16'($urandom), enc_fit(ENC_MIN));
    drain();

    // --- random phases, each under its own register setting
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1:       style = REGS_ONES;
        3:       style = REGS_ZERO;
        5:       style = REGS_WILD;
        6:       style = REGS_RESET;
        default: style = REGS_TUNED;
      endcase
      load_regs(regs_for(style));
      steady = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // occasional switch between idling and back-to-back traffic
        if ($urandom_range(0, 19) == 0) steady = !steady;
        if ($urandom_range(0, 99) < 78) run_move(sent);
        else noise_item(sent);
      end
      drain();
    end

    steady = 1'b0;
    if (mismatch_cnt == 0 && result_backlog == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
